// File: design/can_serial_frame_parser_macros.svh
// Assertion macros for the serial frame parser.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef CAN_SERIAL_FRAME_PARSER_MACROS_SVH
`define CAN_SERIAL_FRAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CSFP_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: label");
`define CSFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`else
`define CSFP_ASSERT(label, cond)
`define CSFP_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// File: design/csfp_pkg.sv
`default_nettype none
package csfp_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int CAN_DATA_BYTES  = 8;

  // The position counter has to hold MAX_FRAME_BYTES itself.
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0] HDR0 = 8'h66;
  localparam logic [7:0] HDR1 = 8'hCC;

  // Byte positions within a frame.
  localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LENH = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LENL = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CMD  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_TYPE = POS_W'(5);
  localparam logic [POS_W-1:0] POS_ID   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_LEN  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_DATA = POS_W'(11);
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME_BYTES);

  typedef enum logic [2:0] {
    KIND_CAN_FRAME = 3'd0,
    KIND_CLEAR_ACK = 3'd1,
    KIND_SET_ACK   = 3'd2,
    KIND_BAUD      = 3'd3,
    KIND_SUM_ERR   = 3'd4,
    KIND_OTHER     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_CAN_FRAME_CODE   = 2'd0,
    REG_CLEAR_ACK_CODE   = 2'd1,
    REG_SET_ACK_CODE     = 2'd2,
    REG_BAUD_REPORT_CODE = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] RST_CAN_FRAME_CODE   = 8'd48;
  localparam logic [7:0] RST_CLEAR_ACK_CODE   = 8'd25;
  localparam logic [7:0] RST_SET_ACK_CODE     = 8'd24;
  localparam logic [7:0] RST_BAUD_REPORT_CODE = 8'd19;

endpackage
`default_nettype wire

// File: design/can_serial_frame_parser.sv
// Byte-serial parser for length-prefixed frames that carry CAN traffic.
// Input channel (in_valid/in_ready/in_rx_byte) takes one received serial
// byte per item. The parser hunts for the header 0x66 0xCC, reads a 16-bit
// big-endian length and collects a command byte, a payload and a checksum.
// When the checksum byte is accepted, one result item is produced on the
// output channel (out_valid/out_ready/out_*); all other bytes produce none.
// The result is valid in the cycle after the checksum byte is accepted.
// Throughput: one byte per cycle while no result waits on the output, set by
// the single register stage holding the parse state and the output register.
// The output register holds a result until the receiver takes it. While a
// result waits and out_ready is low, in_ready is low and no byte is taken;
// a new byte is taken in the same cycle as the waiting result leaves, so
// stalls on the output side pass straight back to the input side.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data)
// writes the four command codes; it is always ready.
// Synchronous active-low reset returns the parser to header hunting,
// empties the output register and loads the default command codes.
`default_nettype none
`include "can_serial_frame_parser_macros.svh"
module can_serial_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // Result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_can_type,
  output logic [31:0]      out_can_id,
  output logic [3:0]       out_data_len,
  output logic [63:0]      out_data_bytes,
  output logic             out_status_ok,
  output logic [7:0]       out_filter_index,
  output logic [10:0]      out_baud_kbps,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire csfp_pkg::cfg_reg_t cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import csfp_pkg::*;

  // Command code registers.
  logic [7:0] can_code_r, clear_code_r, set_code_r, baud_code_r;

  // Parse state.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       type_r, type_nxt;   // also the ack status byte
  logic [31:0]      id_r, id_nxt;
  logic [7:0]       dlen_r, dlen_nxt;
  logic [63:0]      data_r, data_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  can_type_r, can_type_nxt;
  logic [31:0] can_id_r, can_id_nxt;
  logic [3:0]  data_len_r, data_len_nxt;
  logic [63:0] data_bytes_r, data_bytes_nxt;
  logic        status_ok_r, status_ok_nxt;
  logic [7:0]  filter_idx_r, filter_idx_nxt;
  logic [10:0] baud_r, baud_nxt;

  logic in_acc;
  logic out_acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      can_code_r   <= RST_CAN_FRAME_CODE;
      clear_code_r <= RST_CLEAR_ACK_CODE;
      set_code_r   <= RST_SET_ACK_CODE;
      baud_code_r  <= RST_BAUD_REPORT_CODE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAN_FRAME_CODE:   can_code_r   <= cfg_data;
        REG_CLEAR_ACK_CODE:   clear_code_r <= cfg_data;
        REG_SET_ACK_CODE:     set_code_r   <= cfg_data;
        REG_BAUD_REPORT_CODE: baud_code_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // One byte of parsing per accepted item. The result fields come from the
  // stored frame fields, so the checksum byte only drives the compare.
  always_comb begin
    logic [POS_W-1:0] pos_eff;
    logic [15:0]      flen;
    logic [15:0]      rem_dec;
    logic [3:0]       n;
    logic [10:0]      idx_ext;

    pos_eff = (pos_r >= POS_MAX) ? POS_HUNT : pos_r;
    flen    = {len_hi_r, in_rx_byte};
    rem_dec = rem_r - 16'd1;
    n       = (dlen_r > 8'(CAN_DATA_BYTES)) ? 4'(CAN_DATA_BYTES) : dlen_r[3:0];
    idx_ext = {3'b000, id_r[31:24]};

    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    len_hi_nxt = len_hi_r;
    sum_nxt    = sum_r;
    cmd_nxt    = cmd_r;
    type_nxt   = type_r;
    id_nxt     = id_r;
    dlen_nxt   = dlen_r;
    data_nxt   = data_r;

    out_valid_nxt  = out_valid_r && !out_acc;
    kind_nxt       = kind_r;
    can_type_nxt   = can_type_r;
    can_id_nxt     = can_id_r;
    data_len_nxt   = data_len_r;
    data_bytes_nxt = data_bytes_r;
    status_ok_nxt  = status_ok_r;
    filter_idx_nxt = filter_idx_r;
    baud_nxt       = baud_r;

    if (in_acc) begin
      if (pos_eff == POS_HUNT) begin
        pos_nxt = (in_rx_byte == HDR0) ? POS_HDR1 : POS_HUNT;
        rem_nxt = 16'd0;
      end else if (pos_eff == POS_HDR1) begin
        if (in_rx_byte == HDR1) begin
          pos_nxt  = POS_LENH;
          rem_nxt  = 16'd2;
          cmd_nxt  = 8'd0;
          type_nxt = 8'd0;
          id_nxt   = 32'd0;
          dlen_nxt = 8'd0;
          data_nxt = 64'd0;
        end else begin
          // The failing byte is not retried as a first header byte.
          pos_nxt = POS_HUNT;
          rem_nxt = 16'd0;
        end
      end else if (pos_eff == POS_LENH) begin
        len_hi_nxt = in_rx_byte;
        sum_nxt    = in_rx_byte;
        pos_nxt    = POS_LENL;
      end else if (pos_eff == POS_LENL) begin
        sum_nxt = sum_r + in_rx_byte;
        if (flen < 16'd2) begin
          // Too short to hold a command and a checksum: drop the frame.
          pos_nxt = POS_HUNT;
          rem_nxt = 16'd0;
        end else begin
          pos_nxt = POS_CMD;
          rem_nxt = flen;
        end
      end else begin
        rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          // Checksum byte: build the result.
          pos_nxt        = POS_HUNT;
          out_valid_nxt  = 1'b1;
          can_type_nxt   = 8'd0;
          can_id_nxt     = 32'd0;
          data_len_nxt   = 4'd0;
          data_bytes_nxt = 64'd0;
          status_ok_nxt  = 1'b0;
          filter_idx_nxt = 8'd0;
          baud_nxt       = 11'd0;
          if (in_rx_byte != sum_r) begin
            kind_nxt = KIND_SUM_ERR;
          end else if (cmd_r == can_code_r) begin
            kind_nxt     = KIND_CAN_FRAME;
            can_type_nxt = type_r;
            can_id_nxt   = id_r;
            data_len_nxt = n;
            for (int i = 0; i < CAN_DATA_BYTES; i++) begin
              if (4'(i) < n) begin
                data_bytes_nxt[8*i +: 8] = data_r[8*i +: 8];
              end
            end
          end else if (cmd_r == clear_code_r) begin
            kind_nxt      = KIND_CLEAR_ACK;
            status_ok_nxt = (type_r == 8'd0);
          end else if (cmd_r == set_code_r) begin
            kind_nxt       = KIND_SET_ACK;
            status_ok_nxt  = (type_r == 8'd0);
            filter_idx_nxt = id_r[31:24];
          end else if (cmd_r == baud_code_r) begin
            kind_nxt = KIND_BAUD;
            baud_nxt = (idx_ext << 2) + idx_ext;
          end else begin
            kind_nxt = KIND_OTHER;
          end
        end else begin
          sum_nxt = sum_r + in_rx_byte;
          pos_nxt = pos_eff + POS_W'(1);
          if (pos_eff == POS_CMD) begin
            cmd_nxt = in_rx_byte;
          end else if (pos_eff == POS_TYPE) begin
            type_nxt = in_rx_byte;
          end else if (pos_eff == POS_LEN) begin
            dlen_nxt = in_rx_byte;
          end
          // Identifier arrives big-endian, data bytes first in lowest octet.
          for (int i = 0; i < 4; i++) begin
            if (pos_eff == POS_ID + POS_W'(i)) begin
              id_nxt[8*(3-i) +: 8] = in_rx_byte;
            end
          end
          for (int i = 0; i < CAN_DATA_BYTES; i++) begin
            if (pos_eff == POS_DATA + POS_W'(i)) begin
              data_nxt[8*i +: 8] = in_rx_byte;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      rem_r       <= 16'd0;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_hi_r     <= len_hi_nxt;
    cmd_r        <= cmd_nxt;
    type_r       <= type_nxt;
    id_r         <= id_nxt;
    dlen_r       <= dlen_nxt;
    data_r       <= data_nxt;
    kind_r       <= kind_nxt;
    can_type_r   <= can_type_nxt;
    can_id_r     <= can_id_nxt;
    data_len_r   <= data_len_nxt;
    data_bytes_r <= data_bytes_nxt;
    status_ok_r  <= status_ok_nxt;
    filter_idx_r <= filter_idx_nxt;
    baud_r       <= baud_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_can_type     = can_type_r;
  assign out_can_id       = can_id_r;
  assign out_data_len     = data_len_r;
  assign out_data_bytes   = data_bytes_r;
  assign out_status_ok    = status_ok_r;
  assign out_filter_index = filter_idx_r;
  assign out_baud_kbps    = baud_r;

  // The position counter never runs past the frame buffer size.
  `CSFP_ASSERT(a_pos_bound, pos_r <= POS_MAX)
  // Inside the body of a frame, at least the checksum byte is still expected.
  `CSFP_ASSERT_IMPL(a_rem_live, pos_r >= POS_CMD, rem_r != 16'd0)
  // Only CAN frame results carry CAN fields.
  `CSFP_ASSERT_IMPL(a_can_fields, out_valid_r && kind_r != KIND_CAN_FRAME, data_len_r == 4'd0 && can_id_r == 32'd0 && data_bytes_r == 64'd0)

endmodule
`default_nettype wire

// File: tb/tb_can_serial_frame_parser.sv
`timescale 1ns / 100ps
module tb_can_serial_frame_parser;
  import csfp_pkg::*;

  // The watchdog ends the run here.
  localparam int CYCLE_LIMIT = 400000;
  // The result is held in a register after its checksum byte; these spare
  // cycles at the end of settle let the parser come to rest.
  localparam int SETTLE_CYCLES = 4;

  // One decoded frame as it shows up on the result channel.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  can_type;
    logic [31:0] can_id;
    logic [3:0]  data_len;
    logic [63:0] data_bytes;
    logic        status_ok;
    logic [7:0]  filter_index;
    logic [10:0] baud_kbps;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_can_type;
  logic [31:0] out_can_id;
  logic [3:0]  out_data_len;
  logic [63:0] out_data_bytes;
  logic        out_status_ok;
  logic [7:0]  out_filter_index;
  logic [10:0] out_baud_kbps;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index = REG_CAN_FRAME_CODE;
  logic [7:0]  cfg_data = 8'h00;

  can_serial_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_can_type     (out_can_type),
    .out_can_id       (out_can_id),
    .out_data_len     (out_data_len),
    .out_data_bytes   (out_data_bytes),
    .out_status_ok    (out_status_ok),
    .out_filter_index (out_filter_index),
    .out_baud_kbps    (out_baud_kbps),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be sent, results the parser still owes, and the
  // bookkeeping that tells the sequencer when the parser has gone quiet.
  logic [7:0]    tx_bytes[$];
  logic [7:0]    frame_body[$];
  frame_result_t pending_results[$];
  int unsigned   bytes_queued = 0;
  int unsigned   bytes_taken = 0;
  int unsigned   mismatches = 0;
  logic          byte_accepted = 1'b0;
  bit            quiet = 1'b0;
  int unsigned   src_gap = 0;
  int unsigned   sink_gap = 0;

  // Shadow copy of the four command codes, updated on every accepted
  // configuration write.
  logic [7:0] can_code   = RST_CAN_FRAME_CODE;
  logic [7:0] clear_code = RST_CLEAR_ACK_CODE;
  logic [7:0] set_code   = RST_SET_ACK_CODE;
  logic [7:0] baud_code  = RST_BAUD_REPORT_CODE;

  // Shadow copy of the parse state. All of it starts at zero, which is
  // the header hunting state.
  int unsigned pos = 0;
  logic [15:0] left_cnt = '0;
  logic [15:0] frame_len = '0;
  logic [7:0]  sum_acc = '0;
  logic [7:0]  cmd_b = '0;
  logic [7:0]  type_b = '0;
  logic [7:0]  status_b = '0;
  logic [31:0] id_w = '0;
  logic [7:0]  len_b = '0;
  logic [63:0] data_w = '0;

  // Advances the shadow parser by one accepted byte. When the byte closes a
  // frame, the decoded result is appended to the list of owed results.
  task automatic parse_byte(input logic [7:0] b);
    frame_result_t r;
    int unsigned   n;
    // A frame that runs past the buffer is abandoned, and the byte that
    // arrives next is treated as a hunting byte.
    if (pos >= MAX_FRAME_BYTES) pos = 0;
    case (pos)
      0: begin
        if (b == HDR0) pos = 1;
        left_cnt = '0;
      end
      1: begin
        // A wrong second header byte is not itself retried as a first one.
        if (b == HDR1) begin
          pos = 2;
          left_cnt = 16'd2;
          cmd_b = '0;
          type_b = '0;
          status_b = '0;
          id_w = '0;
          len_b = '0;
          data_w = '0;
        end else begin
          pos = 0;
          left_cnt = '0;
        end
      end
      2: begin
        frame_len = {b, 8'h00};
        sum_acc = b;
        pos = 3;
      end
      3: begin
        frame_len[7:0] = b;
        sum_acc = sum_acc + b;
        // A length too short to hold a command and a checksum is dropped.
        if (frame_len < 16'd2) begin
          pos = 0;
          left_cnt = '0;
        end else begin
          left_cnt = frame_len;
          pos = 4;
        end
      end
      default: begin
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == 16'd0) begin
          // This is the checksum byte. Fields that never arrived stay zero.
          r = '0;
          if (b != sum_acc) begin
            r.kind = KIND_SUM_ERR;
          end else if (cmd_b == can_code) begin
            n = (len_b > CAN_DATA_BYTES) ? CAN_DATA_BYTES : len_b;
            r.kind = KIND_CAN_FRAME;
            r.can_type = type_b;
            r.can_id = id_w;
            r.data_len = 4'(n);
            for (int i = 0; i < CAN_DATA_BYTES; i++) begin
              if (i < n) r.data_bytes[8*i +: 8] = data_w[8*i +: 8];
            end
          end else if (cmd_b == clear_code) begin
            r.kind = KIND_CLEAR_ACK;
            r.status_ok = (status_b == 8'h00);
          end else if (cmd_b == set_code) begin
            r.kind = KIND_SET_ACK;
            r.status_ok = (status_b == 8'h00);
            r.filter_index = id_w[31:24];
          end else if (cmd_b == baud_code) begin
            r.kind = KIND_BAUD;
            r.baud_kbps = 11'(id_w[31:24]) * 11'd5;
          end else begin
            r.kind = KIND_OTHER;
          end
          pending_results.push_back(r);
          pos = 0;
        end else begin
          sum_acc = sum_acc + b;
          if (pos == POS_CMD) begin
            cmd_b = b;
          end else if (pos == POS_TYPE) begin
            type_b = b;
            status_b = b;
          end else if (pos >= POS_ID && pos < POS_LEN) begin
            id_w[8*(POS_LEN - 1 - pos) +: 8] = b;
          end else if (pos == POS_LEN) begin
            len_b = b;
          end else if (pos >= POS_DATA && pos < POS_DATA + CAN_DATA_BYTES) begin
            data_w[8*(pos - POS_DATA) +: 8] = b;
          end
          pos = pos + 1;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Everything is sampled at the rising edge. The result is checked before
  // the byte of the same edge is parsed, although a byte accepted now can
  // only produce a result in a later cycle anyway.
  always @(posedge clk) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAN_FRAME_CODE:   can_code = cfg_data;
          REG_CLEAR_ACK_CODE:   clear_code = cfg_data;
          REG_SET_ACK_CODE:     set_code = cfg_data;
          REG_BAUD_REPORT_CODE: baud_code = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.kind = kind_t'(out_kind);
        got.can_type = out_can_type;
        got.can_id = out_can_id;
        got.data_len = out_data_len;
        got.data_bytes = out_data_bytes;
        got.status_ok = out_status_ok;
        got.filter_index = out_filter_index;
        got.baud_kbps = out_baud_kbps;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) $display("result item of kind %0d with none owed", out_kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("can_type", want.can_type, got.can_type);
          check_field("can_id", want.can_id, got.can_id);
          check_field("data_len", want.data_len, got.data_len);
          check_field("data_bytes", want.data_bytes, got.data_bytes);
          check_field("status_ok", want.status_ok, got.status_ok);
          check_field("filter_index", want.filter_index, got.filter_index);
          check_field("baud_kbps", want.baud_kbps, got.baud_kbps);
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_rx_byte);
        bytes_taken++;
      end
    end
    byte_accepted <= rst_n && in_valid && in_ready;
  end

  // Byte driver. A new item is presented only once the previous one has
  // been taken, so valid and the byte stay put while the parser stalls.
  // Gaps are thrown in at random unless the phase is a quiet one.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || byte_accepted)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= tx_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink with random stall bursts.
  always @(negedge clk) begin
    if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic fill_body(input int unsigned count, input bit random_fill,
                           input logic [7:0] value);
    frame_body.delete();
    repeat (count) frame_body.push_back(random_fill ? 8'($urandom_range(0, 255)) : value);
  endtask

  // Wraps frame_body in a header, length, command and checksum. The length
  // counts the command, the payload and the checksum byte.
  task automatic queue_frame(input logic [7:0] cmd, input bit bad_sum);
    logic [15:0] flen;
    logic [7:0]  chk;
    flen = 16'(frame_body.size() + 2);
    chk = flen[15:8] + flen[7:0] + cmd;
    foreach (frame_body[i]) chk = chk + frame_body[i];
    if (bad_sum) chk = chk ^ 8'($urandom_range(1, 255));
    queue_byte(HDR0);
    queue_byte(HDR1);
    queue_byte(flen[15:8]);
    queue_byte(flen[7:0]);
    queue_byte(cmd);
    foreach (frame_body[i]) queue_byte(frame_body[i]);
    queue_byte(chk);
  endtask

  // Mostly one of the configured codes, with the CAN code weighted up.
  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 5))
      0, 1:    return can_code;
      2:       return clear_code;
      3:       return set_code;
      4:       return baud_code;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random traffic: mostly well-formed frames with random content, some
  // with a broken checksum, and the rest line noise, broken headers and
  // too-short lengths. It keeps going until both the byte count and a
  // couple of frames have been reached.
  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned frames;
    int unsigned pick;
    int unsigned sz;
    logic [7:0]  b;
    start = bytes_queued;
    frames = 0;
    while (bytes_queued - start < n_bytes || frames < 2) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        sz = $urandom_range(0, 9);
        if (sz < 4) sz = $urandom_range(0, 13);
        else if (sz < 8) sz = 14;
        else sz = $urandom_range(15, 40);
        fill_body(sz, 1'b1, 8'h00);
        // Keep the CAN length byte mostly in the meaningful range and the
        // ack status byte zero about half the time.
        if (sz > 5 && $urandom_range(0, 3) != 0) frame_body[5] = 8'($urandom_range(0, 9));
        if (sz > 0 && $urandom_range(0, 1) == 0) frame_body[0] = 8'h00;
        queue_frame(pick_cmd(), pick >= 70);
        frames++;
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) == 0) b = HDR0;
          queue_byte(b);
        end
      end else if (pick < 93) begin
        queue_byte(HDR0);
        do b = 8'($urandom_range(0, 255)); while (b == HDR1);
        queue_byte(b);
      end else if (pick < 97) begin
        queue_byte(HDR0);
        queue_byte(HDR1);
        queue_byte(8'h00);
        queue_byte(8'($urandom_range(0, 1)));
      end else begin
        queue_byte(HDR0);
        queue_byte(HDR0);
        queue_byte(HDR1);
      end
    end
  endtask

  // Waits until every queued byte is taken and every owed result has come
  // back. If the parser is still inside a frame, zero bytes push it back to
  // hunting: a zero length is dropped and a running frame just ends.
  task automatic settle();
    do begin
      @(negedge clk);
      while (bytes_taken != bytes_queued || pending_results.size() != 0) @(negedge clk);
      if (pos != 0) begin
        @(posedge clk);
        queue_byte(8'h00);
      end
    end while (pos != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_code(input cfg_reg_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One phase: let the parser come to rest, load a new set of codes, then
  // run random traffic against it.
  task automatic run_phase(input logic [7:0] c_can, input logic [7:0] c_clear,
                           input logic [7:0] c_set, input logic [7:0] c_baud,
                           input int unsigned n_bytes, input bit calm);
    settle();
    write_code(REG_CAN_FRAME_CODE, c_can);
    write_code(REG_CLEAR_ACK_CODE, c_clear);
    write_code(REG_SET_ACK_CODE, c_set);
    write_code(REG_BAUD_REPORT_CODE, c_baud);
    @(posedge clk);
    quiet = calm;
    queue_random_traffic(n_bytes);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset codes.
    // A complete CAN frame with eight data bytes.
    frame_body = {8'hA5, 8'h12, 8'h34, 8'h56, 8'h78, 8'h08,
                  8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
    queue_frame(RST_CAN_FRAME_CODE, 1'b0);
    // All ones: the length byte 0xFF saturates at eight.
    fill_body(14, 1'b0, 8'hFF);
    queue_frame(RST_CAN_FRAME_CODE, 1'b0);
    // Three data bytes announced, eight sent: the rest must be masked.
    fill_body(14, 1'b0, 8'hFF);
    frame_body[0] = 8'h00;
    frame_body[5] = 8'h03;
    queue_frame(RST_CAN_FRAME_CODE, 1'b0);
    // No payload at all, and then a payload cut off inside the id.
    frame_body.delete();
    queue_frame(RST_CAN_FRAME_CODE, 1'b0);
    frame_body = {8'h11, 8'h22, 8'h33};
    queue_frame(RST_CAN_FRAME_CODE, 1'b0);
    // Payload longer than the CAN fields; the tail only feeds the checksum.
    fill_body(30, 1'b1, 8'h00);
    queue_frame(RST_CAN_FRAME_CODE, 1'b0);
    // Acknowledgements with good and bad status, filter index extremes.
    frame_body = {8'h00};
    queue_frame(RST_CLEAR_ACK_CODE, 1'b0);
    frame_body = {8'h80, 8'h01};
    queue_frame(RST_CLEAR_ACK_CODE, 1'b0);
    frame_body = {8'h00, 8'hFF};
    queue_frame(RST_SET_ACK_CODE, 1'b0);
    frame_body = {8'h01, 8'h00};
    queue_frame(RST_SET_ACK_CODE, 1'b0);
    // Baud reports at the top of the range and with no report byte.
    frame_body = {8'h00, 8'hFF};
    queue_frame(RST_BAUD_REPORT_CODE, 1'b0);
    frame_body.delete();
    queue_frame(RST_BAUD_REPORT_CODE, 1'b0);
    // Checksum failure.
    frame_body = {8'hA5, 8'h12, 8'h34, 8'h56, 8'h78, 8'h02, 8'hDE, 8'hAD};
    queue_frame(RST_CAN_FRAME_CODE, 1'b1);
    // Unknown commands, including the extreme command values.
    frame_body = {8'h01, 8'h02, 8'h03};
    queue_frame(8'h77, 1'b0);
    frame_body.delete();
    queue_frame(8'h00, 1'b0);
    frame_body = {8'hFF};
    queue_frame(8'hFF, 1'b0);
    // A bad second header byte that happens to be a first header byte must
    // not restart the header; the frame after it must still decode.
    queue_byte(HDR0);
    queue_byte(HDR0);
    queue_byte(HDR1);
    frame_body = {8'h00};
    queue_frame(RST_CLEAR_ACK_CODE, 1'b0);
    // Lengths of zero and one are dropped.
    queue_byte(HDR0);
    queue_byte(HDR1);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(HDR0);
    queue_byte(HDR1);
    queue_byte(8'h00);
    queue_byte(8'h01);
    frame_body = {8'h00, 8'h0A};
    queue_frame(RST_BAUD_REPORT_CODE, 1'b0);
    // A frame bigger than the buffer forces a resync in mid-frame.
    fill_body(260, 1'b1, 8'h00);
    queue_frame(RST_CAN_FRAME_CODE, 1'b0);
    settle();
    queue_random_traffic(40);

    // All codes equal at both extremes: the CAN code has priority.
    run_phase(8'h00, 8'h00, 8'h00, 8'h00, 30, 1'b0);
    run_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, 30, 1'b0);
    // Clear shares its code with set and baud, then set shares with baud.
    run_phase(8'h30, 8'h41, 8'h41, 8'h41, 30, 1'b0);
    run_phase(8'h10, 8'h20, 8'h52, 8'h52, 30, 1'b1);
    // Random code sets.
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 30, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 30, 1'b0);
    // Back to the default codes for the closing stretch, with no gaps on
    // either side.
    run_phase(RST_CAN_FRAME_CODE, RST_CLEAR_ACK_CODE, RST_SET_ACK_CODE,
              RST_BAUD_REPORT_CODE, 40, 1'b1);
    settle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
